/* rtl/ebcs_pkg.sv */
// Package for the 8-bit CPU subset core: widths, reset values, codes, cost table.
// Used by every module under rtl; depends on nothing.
package ebcs_pkg;

  localparam int AddrBits = 16;
  localparam int MemDepth = 1 << AddrBits;

  localparam logic [15:0] AfReset = 16'h01B0;
  localparam logic [15:0] BcReset = 16'h0804;
  localparam logic [15:0] DeReset = 16'h0201;
  localparam logic [15:0] SpReset = 16'hFFFE;
  localparam logic [15:0] PcReset = 16'h0100;
  localparam logic [7:0]  OpHalt  = 8'h76;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActExec  = 2'd2;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StHalted  = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;
  localparam logic [1:0] StOff     = 2'd3;

  // Memory port operations requested by the controller.
  typedef enum logic [2:0] {
    MEM_IDLE, MEM_RD_ADDR, MEM_WR_ADDR, MEM_RD_PC, MEM_RD_HL, MEM_WR_HL
  } mem_op_e;

  // Datapath register updates requested by the controller.
  typedef enum logic [2:0] {
    UPD_NONE, UPD_OPCODE, UPD_EXEC, UPD_IMM, UPD_IMM_HI, UPD_HALT
  } upd_e;

  typedef struct packed {
    mem_op_e     mem_op;
    logic [1:0]  wsrc;      // 0 input data, 1 (HL)+1, 2 (HL)-1, 3 register B / imm
    upd_e        upd;
    logic        inc_pc;
    logic        charge;
    logic        clear_rd;
    logic        latch_rd;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       halted;
    logic       clearing;
  } stat_t;

  localparam logic [1:0] WsrcData = 2'd0;
  localparam logic [1:0] WsrcInc  = 2'd1;
  localparam logic [1:0] WsrcDec  = 2'd2;
  localparam logic [1:0] WsrcReg  = 2'd3;

  // Cycles charged per opcode.
  function automatic logic [3:0] cost_of(input logic [7:0] op);
    logic [3:0] c;
    c = 4'd1;
    case (op)
      8'h04, 8'h05, 8'h0C, 8'h0D, 8'h14, 8'h15, 8'h1C, 8'h1D, 8'h24, 8'h25,
      8'h2C, 8'h2D, 8'h3C, 8'h3D, 8'h76, 8'h03,
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h87,
      8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h97,
      8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA7,
      8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB7,
      8'hA8, 8'hA9, 8'hAA, 8'h41, 8'h4A, 8'h53, 8'h78: c = 4'd4;
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h3E, 8'h70, 8'h46: c = 4'd7;
      8'h21, 8'h36: c = 4'd10;
      8'h34, 8'h35: c = 4'd11;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  // Opcode classes used by the controller.
  function automatic logic is_ld_imm(input logic [7:0] op);
    return (op < 8'h40) && (op[5:3] != 3'd6) && (op[2:0] == 3'd6);
  endfunction

  function automatic logic is_simple(input logic [7:0] op);
    logic r;
    r = 1'b0;
    if ((op < 8'h40) && (op[5:3] != 3'd6) && (op[2:0] == 3'd4 || op[2:0] == 3'd5))
      r = 1'b1;
    if ((op >= 8'h80) && (op < 8'hB8) && (op[2:0] != 3'd6) &&
        (op[5:3] != 3'd1) && (op[5:3] != 3'd3))
      r = 1'b1;
    case (op)
      8'h00, 8'h41, 8'h4A, 8'h53, 8'h78, 8'h03: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

endpackage

/* rtl/ebcs_datapath.sv */
// Datapath of the CPU subset core: byte memory, register file, cycle sum.
// Depends on ebcs_pkg; driven by ebcs_ctrl.
module ebcs_datapath import ebcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output stat_t       stat_o,
  output logic [7:0]  read_data_o,
  output logic [7:0]  opcode_o,
  output logic [3:0]  op_cycles_o,
  output logic [47:0] total_cycles_o,
  output logic [15:0] pc_o,
  output logic [15:0] af_o,
  output logic [15:0] bc_o,
  output logic [15:0] de_o,
  output logic [15:0] hl_o,
  output logic [15:0] sp_o
);

  logic [7:0]  mem_q [MemDepth];
  logic [7:0]  rdata_q;
  logic [AddrBits-1:0] maddr;
  logic [7:0]  wbyte;
  logic        mwe;
  logic        mre;
  logic [AddrBits:0] clr_q;
  logic        clearing;
  logic [15:0] af_q, bc_q, de_q, hl_q, pc_q, pc_d;
  logic [7:0]  a_d, b_d, c_d, d_d, e_d, h_d, l_d;
  logic [7:0]  op_q, rd_q, src_v, dst_v, alu;
  logic [3:0]  cyc_q;
  logic [47:0] sum_q;
  logic        halt_q;
  logic [2:0]  dst, src;

  assign dst = op_q[5:3];
  assign src = op_q[2:0];
  assign clearing = !clr_q[AddrBits];

  // Clearing pass after reset: one byte a cycle until the whole memory is zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clearing) clr_q <= clr_q + (AddrBits+1)'(1);
  end

  // Memory address and write data selection.
  always_comb begin
    maddr = address_i[AddrBits-1:0];
    mwe   = 1'b0;
    mre   = 1'b0;
    case (ctrl_i.mem_op)
      MEM_RD_ADDR: mre = 1'b1;
      MEM_WR_ADDR: mwe = 1'b1;
      MEM_RD_PC: begin
        maddr = pc_q[AddrBits-1:0];
        mre   = 1'b1;
      end
      MEM_RD_HL: begin
        maddr = hl_q[AddrBits-1:0];
        mre   = 1'b1;
      end
      MEM_WR_HL: begin
        maddr = hl_q[AddrBits-1:0];
        mwe   = 1'b1;
      end
      default: ;
    endcase
    case (ctrl_i.wsrc)
      WsrcInc: wbyte = rdata_q + 8'd1;
      WsrcDec: wbyte = rdata_q - 8'd1;
      WsrcReg: wbyte = (op_q == 8'h70) ? bc_q[15:8] : rdata_q;
      default: wbyte = data_i;
    endcase
    if (clearing) begin
      maddr = clr_q[AddrBits-1:0];
      mwe   = 1'b1;
      wbyte = 8'd0;
    end
  end

  // Single-port byte memory; read data is held until the next read.
  always_ff @(posedge clk_i) begin
    if (mwe) mem_q[maddr] <= wbyte;
    if (mre) rdata_q <= mem_q[maddr];
  end

  // Register read by code.
  function automatic logic [7:0] rsel(input logic [2:0] c, input logic [15:0] af,
      input logic [15:0] bc, input logic [15:0] de, input logic [15:0] hl);
    logic [7:0] v;
    case (c)
      3'd0: v = bc[15:8];
      3'd1: v = bc[7:0];
      3'd2: v = de[15:8];
      3'd3: v = de[7:0];
      3'd4: v = hl[15:8];
      3'd5: v = hl[7:0];
      3'd7: v = af[15:8];
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Instruction execute logic.
  always_comb begin
    src_v = rsel(src, af_q, bc_q, de_q, hl_q);
    dst_v = rsel(dst, af_q, bc_q, de_q, hl_q);
    case (dst)
      3'd0: alu = af_q[15:8] + src_v;
      3'd2: alu = af_q[15:8] - src_v;
      3'd4: alu = af_q[15:8] & src_v;
      3'd5: alu = af_q[15:8] ^ src_v;
      default: alu = af_q[15:8] | src_v;
    endcase
    {a_d, b_d, c_d, d_d, e_d, h_d, l_d} =
      {af_q[15:8], bc_q, de_q, hl_q};
    pc_d = ctrl_i.inc_pc ? pc_q + 16'd1 : pc_q;
    if (ctrl_i.upd == UPD_EXEC) begin
      if (op_q < 8'h40) begin
        if (op_q == 8'h03) {b_d, c_d} = bc_q + 16'd1;
        else if (op_q == 8'h00) ;
        else begin
          case (dst)
            3'd0: b_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
            3'd1: c_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
            3'd2: d_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
            3'd3: e_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
            3'd4: h_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
            3'd5: l_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
            default: a_d = (src == 3'd4) ? dst_v + 8'd1 : dst_v - 8'd1;
          endcase
        end
      end else if (op_q < 8'h80) begin
        // LD B,(HL) takes the byte just read from memory.
        if (op_q == 8'h46) b_d = rdata_q;
        else begin
          case (dst)
            3'd0: b_d = src_v;
            3'd1: c_d = src_v;
            3'd2: d_d = src_v;
            default: a_d = src_v;
          endcase
        end
      end else a_d = alu;
    end else if (ctrl_i.upd == UPD_IMM) begin
      // LD HL,nn: low byte comes first, from the immediate read
      if (op_q == 8'h21) l_d = rdata_q;
      else begin
        case (dst)
          3'd0: b_d = rdata_q;
          3'd1: c_d = rdata_q;
          3'd2: d_d = rdata_q;
          3'd3: e_d = rdata_q;
          3'd4: h_d = rdata_q;
          3'd5: l_d = rdata_q;
          default: a_d = rdata_q;
        endcase
      end
    end else if (ctrl_i.upd == UPD_IMM_HI) begin
      h_d = rdata_q;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= AfReset; bc_q <= BcReset; de_q <= DeReset; hl_q <= '0;
      pc_q <= PcReset; sum_q <= '0; halt_q <= 1'b0;
      op_q <= '0; cyc_q <= '0; rd_q <= '0;
    end else begin
      af_q <= {a_d, af_q[7:0]};
      bc_q <= {b_d, c_d};
      de_q <= {d_d, e_d};
      hl_q <= {h_d, l_d};
      pc_q <= pc_d;
      if (ctrl_i.clear_rd) begin
        op_q <= '0; cyc_q <= '0; rd_q <= '0;
      end
      if (ctrl_i.latch_rd) rd_q <= rdata_q;
      if (ctrl_i.upd == UPD_OPCODE) begin
        op_q  <= rdata_q;
        cyc_q <= cost_of(rdata_q);
      end
      if (ctrl_i.charge) sum_q <= sum_q + {44'd0, cyc_q};
      if (ctrl_i.upd == UPD_HALT) halt_q <= 1'b1;
    end
  end

  assign stat_o         = '{opcode: op_q, halted: halt_q, clearing: clearing};
  assign read_data_o    = rd_q;
  assign opcode_o       = op_q;
  assign op_cycles_o    = cyc_q;
  assign total_cycles_o = sum_q;
  assign pc_o = pc_q;
  assign af_o = af_q;
  assign bc_o = bc_q;
  assign de_o = de_q;
  assign hl_o = hl_q;
  assign sp_o = SpReset;

endmodule

/* rtl/ebcs_ctrl.sv */
// Controller state machine of the CPU subset core: sequences memory and execute.
// Depends on ebcs_pkg; drives ebcs_datapath.
module ebcs_ctrl import ebcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic       power_on_i,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o,
  output logic [1:0] status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  localparam logic [3:0] SIdle = 4'd0, SRdWait = 4'd1, SFetch = 4'd2, SDecode = 4'd3,
                         SImm = 4'd4, SImm2 = 4'd5, SHlRd = 4'd6, SHlMod = 4'd7,
                         SOut = 4'd8, SImmHi = 4'd9, SImmHi2 = 4'd10, SHlSt = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] status_q, status_d;
  logic       ovalid_q;
  logic       acc;
  logic [7:0] op;

  assign op  = stat_i.opcode;
  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SIdle) && !ovalid_q && !stat_i.clearing;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ctrl_o   = '{mem_op: MEM_IDLE, wsrc: WsrcData, upd: UPD_NONE,
                 inc_pc: 1'b0, charge: 1'b0, clear_rd: 1'b0, latch_rd: 1'b0};
    case (state_q)
      SIdle: if (acc) begin
        ctrl_o.clear_rd = 1'b1;
        status_d = StDone;
        case (action_i)
          ActWrite: begin ctrl_o.mem_op = MEM_WR_ADDR; state_d = SOut; end
          ActRead:  begin ctrl_o.mem_op = MEM_RD_ADDR; state_d = SRdWait; end
          ActExec: begin
            if (!power_on_i) begin status_d = StOff; state_d = SOut; end
            else if (stat_i.halted) begin status_d = StHalted; state_d = SOut; end
            else begin
              ctrl_o.mem_op = MEM_RD_PC; ctrl_o.inc_pc = 1'b1; state_d = SFetch;
            end
          end
          default: state_d = SOut;
        endcase
      end
      SRdWait: begin ctrl_o.latch_rd = 1'b1; state_d = SOut; end
      SFetch:  begin ctrl_o.upd = UPD_OPCODE; state_d = SDecode; end
      SDecode: begin
        ctrl_o.charge = 1'b1;
        if (is_simple(op)) begin
          ctrl_o.upd = UPD_EXEC; state_d = SOut;
        end else if (is_ld_imm(op) || op == 8'h21 || op == 8'h36) begin
          ctrl_o.mem_op = MEM_RD_PC; ctrl_o.inc_pc = 1'b1; state_d = SImm;
        end else if (op == 8'h34 || op == 8'h35 || op == 8'h46) begin
          ctrl_o.mem_op = MEM_RD_HL; state_d = SHlRd;
        end else if (op == 8'h70) begin
          ctrl_o.mem_op = MEM_WR_HL; ctrl_o.wsrc = WsrcReg; state_d = SOut;
        end else if (op == OpHalt) begin
          ctrl_o.upd = UPD_HALT; status_d = StHalted; state_d = SOut;
        end else begin
          ctrl_o.upd = UPD_HALT; status_d = StInvalid; state_d = SOut;
        end
      end
      SImm: state_d = SImm2;
      SImm2: begin
        if (op == 8'h36) begin
          ctrl_o.mem_op = MEM_WR_HL; ctrl_o.wsrc = WsrcReg; state_d = SOut;
        end else if (op == 8'h21) begin
          ctrl_o.upd = UPD_IMM;
          ctrl_o.mem_op = MEM_RD_PC; ctrl_o.inc_pc = 1'b1; state_d = SImmHi;
        end else begin
          ctrl_o.upd = UPD_IMM; state_d = SOut;
        end
      end
      SImmHi:  state_d = SImmHi2;
      SImmHi2: begin ctrl_o.upd = UPD_IMM_HI; state_d = SOut; end
      SHlRd:   state_d = SHlMod;
      SHlMod: begin
        if (op == 8'h46) begin ctrl_o.upd = UPD_EXEC; state_d = SOut; end
        else begin
          ctrl_o.mem_op = MEM_WR_HL;
          ctrl_o.wsrc = (op == 8'h34) ? WsrcInc : WsrcDec;
          state_d = SHlSt;
        end
      end
      SHlSt: state_d = SOut;
      SOut:  state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; status_q <= StDone; ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (state_q == SOut) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign status_o    = status_q;
  assign out_valid_o = ovalid_q;

  // A new word is never taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q |-> !in_ready_o)
    else $error("input taken with result pending");
  // Every pass through the result state raises the output valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) |=> ovalid_q)
    else $error("result not raised");
  // The controller leaves idle only on acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && !acc) |=> state_q == SIdle)
    else $error("controller left idle without a word");

endmodule

/* rtl/eight_bit_cpu_subset_core_unit.sv */
// Top level of the 8-bit CPU subset core: APB register, controller and datapath.
// Depends on ebcs_pkg, ebcs_ctrl and ebcs_datapath.

// Each input word writes or reads one byte of the 64 KiB internal memory, or
// executes one instruction at PC, and yields one result word. A further word
// is accepted only after the result has been taken. An instruction's steps
// are set by the single memory port: opcode fetch, up to two immediate
// fetches with their registered read latency, and the read-modify-write of
// (HL). After reset the memory is cleared one byte a cycle, during which the
// input is not ready. power_on is register 0 at byte address 0 of the APB
// port.
module eight_bit_cpu_subset_core_unit import ebcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  status_o,
  output logic [7:0]  opcode_o,
  output logic [3:0]  op_cycles_o,
  output logic [47:0] total_cycles_o,
  output logic [15:0] pc_out_o,
  output logic [15:0] af_out_o,
  output logic [15:0] bc_out_o,
  output logic [15:0] de_out_o,
  output logic [15:0] hl_out_o,
  output logic [15:0] sp_out_o
);

  logic  power_q;
  ctrl_t ctrl;
  stat_t stat;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) power_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == 1'b0) power_q <= pwdata[0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {31'd0, power_q} : 32'd0;

  ebcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
    .power_on_i(power_q), .stat_i(stat), .ctrl_o(ctrl), .status_o,
    .out_valid_o, .out_ready_i
  );

  ebcs_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .address_i, .data_i, .stat_o(stat),
    .read_data_o, .opcode_o, .op_cycles_o, .total_cycles_o,
    .pc_o(pc_out_o), .af_o(af_out_o), .bc_o(bc_out_o), .de_o(de_out_o),
    .hl_o(hl_out_o), .sp_o(sp_out_o)
  );

endmodule
